FILE: rtl/core/msc_pkg.sv
// Shared types, constants and coefficient helper for the motor speed control loop.
package msc_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int STATE_W_DEF   = 48;

    localparam int CNT_W     = 32;
    localparam int REF_W     = 24;
    localparam int POWER_W   = 8;
    localparam int SPEED_W   = 32;
    localparam int COEF_W    = 32;
    localparam int MUL_SPLIT = 32;
    localparam int STEP_W    = 5;

    localparam int POWER_LIMIT = 100;

    localparam logic [REF_W-1:0] REF_RESET = 24'd458752;

    // Coefficients in units of 1e-9
    localparam logic [63:0] COEF_ONE  = 64'd1000000000;
    localparam logic [63:0] COEF_HALF = 64'd500000000;
    localparam logic [63:0] E9_SPEED  = 64'd53987577;
    localparam logic [63:0] E9_FILT   = 64'd969067417;
    localparam logic [63:0] E9_CE     = 64'd32394271000;
    localparam logic [63:0] E9_CE1    = 64'd61628125000;
    localparam logic [63:0] E9_CE2    = 64'd29310937000;
    localparam logic [63:0] E9_CY1    = 64'd1666666700;
    localparam logic [63:0] E9_CY2    = 64'd666666700;

    // round to nearest at frac fraction bits; elaboration time only
    function automatic logic [COEF_W-1:0] coef_q(input logic [63:0] e9, input int frac);
        logic [63:0] q;
        begin
            q = ((e9 << frac) + COEF_HALF) / COEF_ONE;
            return q[COEF_W-1:0];
        end
    endfunction

    typedef enum logic [1:0] {
        JMP_NEXT    = 2'd0,
        JMP_WAIT_IN = 2'd1,
        JMP_COMMIT  = 2'd2
    } jmp_t;

    typedef enum logic [1:0] {
        MUL_NONE = 2'd0,
        MUL_LO   = 2'd1,
        MUL_HI   = 2'd2
    } mul_op_t;

    typedef enum logic [2:0] {
        OPA_DELTA = 3'd0,
        OPA_LFILT = 3'd1,
        OPA_P1    = 3'd2,
        OPA_P2    = 3'd3,
        OPA_ERR   = 3'd4,
        OPA_E1    = 3'd5,
        OPA_E2    = 3'd6
    } opa_sel_t;

    typedef enum logic [2:0] {
        CF_SPEED = 3'd0,
        CF_FILT  = 3'd1,
        CF_CY1   = 3'd2,
        CF_CY2   = 3'd3,
        CF_CE    = 3'd4,
        CF_CE1   = 3'd5,
        CF_CE2   = 3'd6
    } coef_sel_t;

    typedef enum logic [2:0] {
        ACC_HOLD      = 3'd0,
        ACC_LOAD_PLOW = 3'd1,
        ACC_ADD_RAW   = 3'd2,
        ACC_ADD_RND   = 3'd3,
        ACC_SUB_RND   = 3'd4,
        ACC_LOAD_REF  = 3'd5,
        ACC_SUB_FILT  = 3'd6,
        ACC_LOAD_RND  = 3'd7
    } acc_op_t;

    typedef enum logic [1:0] {
        WR_NONE = 2'd0,
        WR_RAW  = 2'd1,
        WR_FILT = 2'd2,
        WR_ERR  = 2'd3
    } wr_sel_t;

    typedef struct packed {
        jmp_t      jmp;
        mul_op_t   mul;
        opa_sel_t  opa;
        coef_sel_t coef;
        acc_op_t   acc;
        wr_sel_t   wr;
    } uword_t;

    typedef struct packed {
        uword_t uw;
        logic   latch;
        logic   commit;
    } ctrl_t;

endpackage

FILE: rtl/core/msc_sequencer.sv
// Microcode ROM, step counter and jump logic for the speed control loop.
module msc_sequencer (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           count_valid,
    input  logic           out_free,
    output logic           count_stall,
    output msc_pkg::ctrl_t ctrl
);

    function automatic msc_pkg::uword_t ucode(input logic [msc_pkg::STEP_W-1:0] s);
        msc_pkg::uword_t w;
        begin
            w.jmp  = msc_pkg::JMP_NEXT;
            w.mul  = msc_pkg::MUL_NONE;
            w.opa  = msc_pkg::OPA_DELTA;
            w.coef = msc_pkg::CF_SPEED;
            w.acc  = msc_pkg::ACC_HOLD;
            w.wr   = msc_pkg::WR_NONE;
            case (s)
                5'd0:  w.jmp = msc_pkg::JMP_WAIT_IN;
                5'd1:  w.mul = msc_pkg::MUL_LO;
                5'd2:  w.mul = msc_pkg::MUL_HI;
                5'd3:
                begin
                    w.mul  = msc_pkg::MUL_LO;
                    w.opa  = msc_pkg::OPA_LFILT;
                    w.coef = msc_pkg::CF_FILT;
                    w.acc  = msc_pkg::ACC_LOAD_PLOW;
                end
                5'd4:
                begin
                    w.mul  = msc_pkg::MUL_HI;
                    w.opa  = msc_pkg::OPA_LFILT;
                    w.coef = msc_pkg::CF_FILT;
                    w.acc  = msc_pkg::ACC_ADD_RAW;
                    w.wr   = msc_pkg::WR_RAW;
                end
                5'd5:
                begin
                    w.mul  = msc_pkg::MUL_LO;
                    w.opa  = msc_pkg::OPA_P1;
                    w.coef = msc_pkg::CF_CY1;
                    w.acc  = msc_pkg::ACC_ADD_RND;
                end
                5'd6:
                begin
                    w.mul  = msc_pkg::MUL_HI;
                    w.opa  = msc_pkg::OPA_P1;
                    w.coef = msc_pkg::CF_CY1;
                    w.acc  = msc_pkg::ACC_LOAD_REF;
                    w.wr   = msc_pkg::WR_FILT;
                end
                5'd7:  w.acc = msc_pkg::ACC_SUB_FILT;
                5'd8:
                begin
                    // error is done; power sum starts from the p1 term
                    w.mul  = msc_pkg::MUL_LO;
                    w.opa  = msc_pkg::OPA_P2;
                    w.coef = msc_pkg::CF_CY2;
                    w.acc  = msc_pkg::ACC_LOAD_RND;
                    w.wr   = msc_pkg::WR_ERR;
                end
                5'd9:
                begin
                    w.mul  = msc_pkg::MUL_HI;
                    w.opa  = msc_pkg::OPA_P2;
                    w.coef = msc_pkg::CF_CY2;
                end
                5'd10:
                begin
                    w.mul  = msc_pkg::MUL_LO;
                    w.opa  = msc_pkg::OPA_ERR;
                    w.coef = msc_pkg::CF_CE;
                    w.acc  = msc_pkg::ACC_SUB_RND;
                end
                5'd11:
                begin
                    w.mul  = msc_pkg::MUL_HI;
                    w.opa  = msc_pkg::OPA_ERR;
                    w.coef = msc_pkg::CF_CE;
                end
                5'd12:
                begin
                    w.mul  = msc_pkg::MUL_LO;
                    w.opa  = msc_pkg::OPA_E1;
                    w.coef = msc_pkg::CF_CE1;
                    w.acc  = msc_pkg::ACC_ADD_RND;
                end
                5'd13:
                begin
                    w.mul  = msc_pkg::MUL_HI;
                    w.opa  = msc_pkg::OPA_E1;
                    w.coef = msc_pkg::CF_CE1;
                end
                5'd14:
                begin
                    w.mul  = msc_pkg::MUL_LO;
                    w.opa  = msc_pkg::OPA_E2;
                    w.coef = msc_pkg::CF_CE2;
                    w.acc  = msc_pkg::ACC_SUB_RND;
                end
                5'd15:
                begin
                    w.mul  = msc_pkg::MUL_HI;
                    w.opa  = msc_pkg::OPA_E2;
                    w.coef = msc_pkg::CF_CE2;
                end
                5'd16: w.acc = msc_pkg::ACC_ADD_RND;
                5'd17: w.jmp = msc_pkg::JMP_COMMIT;
                default: w.jmp = msc_pkg::JMP_NEXT;
            endcase
            return w;
        end
    endfunction

    logic [msc_pkg::STEP_W-1:0] step_reg;
    logic [msc_pkg::STEP_W-1:0] step_next;
    msc_pkg::uword_t            uw;

    assign uw          = ucode(step_reg);
    assign count_stall = (uw.jmp != msc_pkg::JMP_WAIT_IN);

    always_comb
    begin
        ctrl.uw     = uw;
        ctrl.latch  = 1'b0;
        ctrl.commit = 1'b0;
        step_next   = step_reg + 1'b1;
        case (uw.jmp)
            msc_pkg::JMP_WAIT_IN:
            begin
                ctrl.latch = count_valid;
                if (!count_valid)
                begin
                    step_next = step_reg;
                end
            end
            msc_pkg::JMP_COMMIT:
            begin
                ctrl.commit = out_free;
                step_next   = out_free ? '0 : step_reg;
            end
            default: step_next = step_reg + 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

FILE: rtl/core/msc_datapath.sv
// Shared split multiplier, accumulator, loop state and result register.
module msc_datapath #(
    parameter int FRAC_BITS = msc_pkg::FRAC_BITS_DEF,
    parameter int STATE_W   = msc_pkg::STATE_W_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  msc_pkg::ctrl_t                      ctrl,
    input  logic                                cfg_write,
    input  logic [msc_pkg::REF_W-1:0]           cfg_data,
    input  logic [msc_pkg::CNT_W-1:0]           encoder_count,
    input  logic                                result_stall,
    output logic                                out_free,
    output logic                                result_valid,
    output logic signed [msc_pkg::POWER_W-1:0]  motor_power,
    output logic signed [msc_pkg::SPEED_W-1:0]  filtered_speed,
    output logic                                power_clamped
);

    localparam int PW    = STATE_W + FRAC_BITS;
    localparam int HW    = STATE_W - msc_pkg::MUL_SPLIT;
    localparam int CW    = msc_pkg::COEF_W;
    localparam int IW    = STATE_W + 1 - FRAC_BITS;

    localparam logic [CW-1:0] K_SPEED = msc_pkg::coef_q(msc_pkg::E9_SPEED, FRAC_BITS);
    localparam logic [CW-1:0] K_FILT  = msc_pkg::coef_q(msc_pkg::E9_FILT, FRAC_BITS);
    localparam logic [CW-1:0] K_CE    = msc_pkg::coef_q(msc_pkg::E9_CE, FRAC_BITS);
    localparam logic [CW-1:0] K_CE1   = msc_pkg::coef_q(msc_pkg::E9_CE1, FRAC_BITS);
    localparam logic [CW-1:0] K_CE2   = msc_pkg::coef_q(msc_pkg::E9_CE2, FRAC_BITS);
    localparam logic [CW-1:0] K_CY1   = msc_pkg::coef_q(msc_pkg::E9_CY1, FRAC_BITS);
    localparam logic [CW-1:0] K_CY2   = msc_pkg::coef_q(msc_pkg::E9_CY2, FRAC_BITS);

    logic signed [msc_pkg::REF_W-1:0] ref_reg;
    logic [msc_pkg::CNT_W-1:0]        cnt_reg;
    logic [msc_pkg::CNT_W-1:0]        last_count_reg;
    logic [STATE_W-1:0]               last_raw_reg;
    logic [STATE_W-1:0]               last_filt_reg;
    logic [STATE_W-1:0]               e1_reg;
    logic [STATE_W-1:0]               e2_reg;
    logic [STATE_W-1:0]               p1_reg;
    logic [STATE_W-1:0]               p2_reg;
    logic [STATE_W-1:0]               raw_new_reg;
    logic [STATE_W-1:0]               filt_new_reg;
    logic [STATE_W-1:0]               err_new_reg;
    logic [STATE_W-1:0]               acc_reg;
    logic [STATE_W-1:0]               acc_next;
    logic [PW-1:0]                    prod_reg;
    logic [PW-1:0]                    prod_next;

    logic                             result_valid_reg;
    logic signed [msc_pkg::POWER_W-1:0] motor_power_reg;
    logic signed [msc_pkg::SPEED_W-1:0] filtered_speed_reg;
    logic                             power_clamped_reg;

    logic [msc_pkg::CNT_W-1:0]        delta;
    logic [STATE_W-1:0]               opa;
    logic [CW-1:0]                    coef_v;
    logic [63:0]                      pp_lo;
    logic signed [HW+CW:0]            pp_hi;
    logic [PW-1:0]                    hi_term;
    logic [STATE_W-1:0]               rnd_q;
    logic                             rnd_b;

    logic [STATE_W-msc_pkg::SPEED_W:0] filt_top;
    logic signed [msc_pkg::SPEED_W-1:0] speed_sat;
    logic                             pw_neg;
    logic [STATE_W:0]                 mag_full;
    logic [IW-1:0]                    mag_int;
    logic                             over;
    logic [msc_pkg::POWER_W-1:0]      mag_c;
    logic [msc_pkg::POWER_W-1:0]      power_v;

    assign delta = cnt_reg - last_count_reg;

    always_comb
    begin
        case (ctrl.uw.opa)
            msc_pkg::OPA_DELTA: opa = STATE_W'(signed'(delta));
            msc_pkg::OPA_LFILT: opa = last_filt_reg;
            msc_pkg::OPA_P1:    opa = p1_reg;
            msc_pkg::OPA_P2:    opa = p2_reg;
            msc_pkg::OPA_ERR:   opa = err_new_reg;
            msc_pkg::OPA_E1:    opa = e1_reg;
            msc_pkg::OPA_E2:    opa = e2_reg;
            default:            opa = '0;
        endcase
        case (ctrl.uw.coef)
            msc_pkg::CF_SPEED: coef_v = K_SPEED;
            msc_pkg::CF_FILT:  coef_v = K_FILT;
            msc_pkg::CF_CY1:   coef_v = K_CY1;
            msc_pkg::CF_CY2:   coef_v = K_CY2;
            msc_pkg::CF_CE:    coef_v = K_CE;
            msc_pkg::CF_CE1:   coef_v = K_CE1;
            msc_pkg::CF_CE2:   coef_v = K_CE2;
            default:           coef_v = '0;
        endcase
    end

    // low half unsigned, upper half signed; the sum is the signed product truncated to PW bits
    assign pp_lo   = 64'(opa[msc_pkg::MUL_SPLIT-1:0]) * 64'(coef_v);
    assign pp_hi   = signed'(opa[STATE_W-1:msc_pkg::MUL_SPLIT]) * signed'({1'b0, coef_v});
    assign hi_term = PW'(pp_hi) << msc_pkg::MUL_SPLIT;

    always_comb
    begin
        case (ctrl.uw.mul)
            msc_pkg::MUL_LO: prod_next = PW'(pp_lo);
            msc_pkg::MUL_HI: prod_next = prod_reg + hi_term;
            default:         prod_next = prod_reg;
        endcase
    end

    // round half up: floor plus the first dropped bit as carry-in
    assign rnd_q = prod_reg[PW-1:FRAC_BITS];
    assign rnd_b = prod_reg[FRAC_BITS-1];

    always_comb
    begin
        case (ctrl.uw.acc)
            msc_pkg::ACC_LOAD_PLOW: acc_next = prod_reg[STATE_W-1:0];
            msc_pkg::ACC_ADD_RAW:   acc_next = acc_reg + last_raw_reg;
            msc_pkg::ACC_ADD_RND:   acc_next = acc_reg + rnd_q + STATE_W'(rnd_b);
            msc_pkg::ACC_SUB_RND:   acc_next = acc_reg + ~rnd_q + STATE_W'(!rnd_b);
            msc_pkg::ACC_LOAD_REF:  acc_next = STATE_W'(ref_reg);
            msc_pkg::ACC_SUB_FILT:  acc_next = acc_reg - filt_new_reg;
            msc_pkg::ACC_LOAD_RND:  acc_next = rnd_q + STATE_W'(rnd_b);
            default:                acc_next = acc_reg;
        endcase
    end

    // filtered speed saturation
    assign filt_top = filt_new_reg[STATE_W-1:msc_pkg::SPEED_W-1];
    always_comb
    begin
        if ((&filt_top) || !(|filt_top))
        begin
            speed_sat = filt_new_reg[msc_pkg::SPEED_W-1:0];
        end
        else if (filt_new_reg[STATE_W-1])
        begin
            speed_sat = {1'b1, {(msc_pkg::SPEED_W-1){1'b0}}};
        end
        else
        begin
            speed_sat = {1'b0, {(msc_pkg::SPEED_W-1){1'b1}}};
        end
    end

    // power: magnitude truncated toward zero, then clamped
    assign pw_neg   = acc_reg[STATE_W-1];
    assign mag_full = pw_neg ? ((STATE_W+1)'(0) - {acc_reg[STATE_W-1], acc_reg})
                             : {1'b0, acc_reg};
    assign mag_int  = mag_full[STATE_W:FRAC_BITS];
    assign over     = (mag_int > IW'(msc_pkg::POWER_LIMIT));
    assign mag_c    = over ? msc_pkg::POWER_W'(msc_pkg::POWER_LIMIT)
                           : mag_int[msc_pkg::POWER_W-1:0];
    assign power_v  = pw_neg ? (msc_pkg::POWER_W'(0) - mag_c) : mag_c;

    assign out_free = !result_valid_reg || !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_reg          <= msc_pkg::REF_RESET;
            last_count_reg   <= '0;
            last_raw_reg     <= '0;
            last_filt_reg    <= '0;
            e1_reg           <= '0;
            e2_reg           <= '0;
            p1_reg           <= '0;
            p2_reg           <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                ref_reg <= cfg_data;
            end
            if (ctrl.commit)
            begin
                last_count_reg   <= cnt_reg;
                last_raw_reg     <= raw_new_reg;
                last_filt_reg    <= filt_new_reg;
                e2_reg           <= e1_reg;
                e1_reg           <= err_new_reg;
                p2_reg           <= p1_reg;
                p1_reg           <= acc_reg;
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        if (ctrl.latch)
        begin
            cnt_reg <= encoder_count;
        end
        case (ctrl.uw.wr)
            msc_pkg::WR_RAW:  raw_new_reg  <= acc_reg;
            msc_pkg::WR_FILT: filt_new_reg <= acc_reg;
            msc_pkg::WR_ERR:  err_new_reg  <= acc_reg;
            default:          ;
        endcase
        if (ctrl.commit)
        begin
            motor_power_reg    <= power_v;
            filtered_speed_reg <= speed_sat;
            power_clamped_reg  <= over;
        end
    end

    assign result_valid   = result_valid_reg;
    assign motor_power    = motor_power_reg;
    assign filtered_speed = filtered_speed_reg;
    assign power_clamped  = power_clamped_reg;

endmodule

FILE: rtl/core/motor_speed_control_loop_unit.sv
// Top level of the motor speed control loop: sequencer plus datapath.
//
//  channel   handshake                    payload
//  --------  ---------------------------  ----------------------------------------------
//  count     count_valid / count_stall    encoder_count
//  result    result_valid / result_stall  motor_power, filtered_speed, power_clamped
//  config    cfg_write                    cfg_data (speed setpoint)
//
// One beat per pass: the accept step, 16 microcode steps through the one shared split
// multiplier (a low and a high step per coefficient product) and accumulator, and
// a commit step. The count channel is open only at the accept step.
// Reset clears the loop state and sets the reference to 7.0 rad/s.
// The commit step holds while a previous result beat is still stalled; a result
// beat waits in the output register while the next count beat is taken.
module motor_speed_control_loop_unit #(
    parameter int FRAC_BITS = msc_pkg::FRAC_BITS_DEF,
    parameter int STATE_W   = msc_pkg::STATE_W_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                count_valid,
    output logic                                count_stall,
    input  logic [msc_pkg::CNT_W-1:0]           encoder_count,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic signed [msc_pkg::POWER_W-1:0]  motor_power,
    output logic signed [msc_pkg::SPEED_W-1:0]  filtered_speed,
    output logic                                power_clamped,
    input  logic                                cfg_write,
    input  logic [msc_pkg::REF_W-1:0]           cfg_data
);

    msc_pkg::ctrl_t ctrl;
    logic           out_free;

    msc_sequencer u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .count_valid (count_valid),
        .out_free    (out_free),
        .count_stall (count_stall),
        .ctrl        (ctrl)
    );

    msc_datapath #(
        .FRAC_BITS (FRAC_BITS),
        .STATE_W   (STATE_W)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (ctrl),
        .cfg_write      (cfg_write),
        .cfg_data       (cfg_data),
        .encoder_count  (encoder_count),
        .result_stall   (result_stall),
        .out_free       (out_free),
        .result_valid   (result_valid),
        .motor_power    (motor_power),
        .filtered_speed (filtered_speed),
        .power_clamped  (power_clamped)
    );

endmodule
